// ===== rtl/core/bmp_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types, codes and the RGB565 packing function of the bitmap pixel
// converter.
// ----------------------------------------------------------------------------
package bmp_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int WIDTH_W    = 13;   // image width, pixel column
   localparam int CNT_W      = 15;   // bytes into the padded row
   localparam int COLOR_W    = 24;
   localparam int PIXEL_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 2'd1;

   typedef enum logic [1:0] {
      CMD_DATA    = 2'd0,
      CMD_PALETTE = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_1BPP  = 2'd0,
      MODE_4BPP  = 2'd1,
      MODE_8BPP  = 2'd2,
      MODE_24BPP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_BLUE  = 2'd0,
      PH_GREEN = 2'd1,
      PH_RED   = 2'd2
   } phase_type;

   // One accepted data byte, as handed to the pixel emitter.
   typedef struct packed {
      logic                 valid;
      mode_type             mode;
      logic [7:0]           bits;
      logic [3:0]           count;     // pixels to give, 1..8
      logic                 row_end;   // last pixel closes the row
      logic [PIXEL_W-1:0]   px24;
      logic                 oob_a;     // palette index out of range
      logic                 oob_b;
   } job_type;

   // red 23:16, green 15:8, blue 7:0 -> red 15:11, green 10:5, blue 4:0
   function automatic logic [PIXEL_W-1:0] to565(input logic [COLOR_W-1:0] c);
      return {c[23:19], c[15:10], c[7:3]};
   endfunction

endpackage

// ===== rtl/core/bmp_pixel_to_rgb565.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_to_rgb565
// Bitmap pixel byte stream to RGB565 converter: 1, 4, 8 and 24 bpp rows
// padded to four bytes, palette loaded in band.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | valid, stall, cmd, data_byte, pal idx/color | in
//   rsp     | valid, stall, pixel, row_end, last      | out
//   csr     | valid, ready, index, data               | in
//
// A data byte gives 0 to 8 pixels, one rsp beat per cycle while rsp is not
// stalled; the next req beat is taken in the cycle its predecessor's last
// pixel moves into the rsp register.
// Palette reads use the RAM's two read ports, issued when the byte is accepted.
// Reset is synchronous; the palette is not cleared.
// rsp stall holds the result register and, once the emitter is full, req.
// ----------------------------------------------------------------------------
module bmp_pixel_to_rgb565 import bmp_pkg::*; #(
   parameter int MAX_WIDTH     = 4096,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_cmd,
   input  logic [7:0]             req_data_byte,
   input  logic [7:0]             req_palette_index,
   input  logic [COLOR_W-1:0]     req_palette_color,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_pixel,
   output logic                   rsp_row_end,
   output logic                   rsp_last,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam logic [16:0] MAXW  = 17'(MAX_WIDTH);
   localparam logic [8:0]  PDEPTH = 9'(PALETTE_DEPTH);

   mode_type             mode_ff;
   logic [WIDTH_W-1:0]   width_ff;
   logic [WIDTH_W-1:0]   col_ff,   col_in;
   logic [CNT_W-1:0]     cnt_ff,   cnt_in;
   phase_type            phase_ff, phase_in;
   logic [7:0]           blue_ff,  blue_in;
   logic [7:0]           green_ff, green_in;

   logic                 accept;
   logic                 job_ready;
   job_type              job;
   logic [WIDTH_W-1:0]   eff_w;
   logic [17:0]          row_bits;
   logic [CNT_W-1:0]     row_bytes;
   logic [CNT_W-1:0]     cnt_plus;
   logic                 row_wrap;
   logic [WIDTH_W-1:0]   room;
   logic [3:0]           cand;
   logic [3:0]           n_px;
   logic [7:0]           rd_a_full;
   logic [7:0]           rd_b_full;
   logic                 pal_we;
   logic                 pal_re;
   logic [COLOR_W-1:0]   pal_a;
   logic [COLOR_W-1:0]   pal_b;

   assign csr_ready = 1'b1;
   assign req_stall = !job_ready;
   assign accept    = req_valid && job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_24BPP;
         width_ff <= 13'd320;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:  mode_ff  <= mode_type'(csr_data[1:0]);
            CSR_WIDTH: width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective width and padded row length in bytes
   always_comb begin
      eff_w = ({4'b0, width_ff} > MAXW) ? MAXW[WIDTH_W-1:0] : width_ff;
      case (mode_ff)
         MODE_1BPP:  row_bits = 18'(eff_w);
         MODE_4BPP:  row_bits = 18'(eff_w) << 2;
         MODE_8BPP:  row_bits = 18'(eff_w) << 3;
         default:    row_bits = (18'(eff_w) << 4) + (18'(eff_w) << 3);
      endcase
      row_bytes = CNT_W'(((row_bits + 18'd31) >> 5) << 2);
      cnt_plus  = cnt_ff + CNT_W'(1);
      row_wrap  = (cnt_plus >= row_bytes);
      room      = (col_ff < eff_w) ? (eff_w - col_ff) : '0;
   end

   always_comb begin
      col_in   = col_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      blue_in  = blue_ff;
      green_in = green_ff;
      pal_we   = 1'b0;
      pal_re   = 1'b0;
      cand     = 4'd0;
      job      = '0;
      job.mode = mode_ff;
      job.bits = req_data_byte;
      job.px24 = to565({req_data_byte, green_ff, blue_ff});

      case (mode_ff)
         MODE_4BPP: begin
            rd_a_full = {4'b0, req_data_byte[7:4]};
            rd_b_full = {4'b0, req_data_byte[3:0]};
         end
         default: begin
            rd_a_full = req_data_byte;
            rd_b_full = req_data_byte;
         end
      endcase
      job.oob_a = ({1'b0, rd_a_full} >= PDEPTH);
      job.oob_b = ({1'b0, rd_b_full} >= PDEPTH);

      case (mode_ff)
         MODE_1BPP: cand = 4'd8;
         MODE_4BPP: cand = 4'd2;
         MODE_8BPP: cand = 4'd1;
         default:   cand = (col_ff < eff_w && phase_ff == PH_RED) ? 4'd1 : 4'd0;
      endcase
      n_px = (room >= WIDTH_W'(cand)) ? cand : room[3:0];
      job.count   = n_px;
      job.row_end = ((col_ff + WIDTH_W'(n_px)) == eff_w);

      if (accept) begin
         case (req_cmd)
            CMD_DATA: begin
               job.valid = (n_px != 4'd0);
               pal_re    = (mode_ff == MODE_4BPP) || (mode_ff == MODE_8BPP);
               if (mode_ff == MODE_24BPP && col_ff < eff_w) begin
                  case (phase_ff)
                     PH_BLUE: begin
                        blue_in  = req_data_byte;
                        phase_in = PH_GREEN;
                     end
                     PH_GREEN: begin
                        green_in = req_data_byte;
                        phase_in = PH_RED;
                     end
                     default: phase_in = PH_BLUE;
                  endcase
               end
               if (row_wrap) begin
                  cnt_in   = '0;
                  col_in   = '0;
                  phase_in = PH_BLUE;
               end else begin
                  cnt_in = cnt_plus;
                  col_in = col_ff + WIDTH_W'(n_px);
               end
            end
            CMD_PALETTE: pal_we = ({1'b0, req_palette_index} < PDEPTH);
            CMD_RESTART: begin
               col_in   = '0;
               cnt_in   = '0;
               phase_in = PH_BLUE;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         cnt_ff   <= '0;
         phase_ff <= PH_BLUE;
         blue_ff  <= '0;
         green_ff <= '0;
      end else begin
         col_ff   <= col_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         blue_ff  <= blue_in;
         green_ff <= green_in;
      end
   end

   bmp_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock     (clock),
      .wr_en     (pal_we),
      .wr_addr   (req_palette_index[PAL_AW-1:0]),
      .wr_data   (req_palette_color),
      .rd_en     (pal_re),
      .rd_addr_a (rd_a_full[PAL_AW-1:0]),
      .rd_addr_b (rd_b_full[PAL_AW-1:0]),
      .rd_data_a (pal_a),
      .rd_data_b (pal_b)
   );

   bmp_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .job_in      (job),
      .pal_a       (pal_a),
      .pal_b       (pal_b),
      .job_ready   (job_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pixel   (rsp_pixel),
      .rsp_row_end (rsp_row_end),
      .rsp_last    (rsp_last)
   );

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_RESTART |=> col_ff == '0 && cnt_ff == '0
         && phase_ff == PH_BLUE)
      else $error("restart did not clear the row position");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_DATA && row_wrap |=> col_ff == '0 && cnt_ff == '0)
      else $error("row position not cleared at end of padded row");

endmodule

// ===== rtl/core/bmp_ram.sv =====
// ----------------------------------------------------------------------------
// bmp_ram
// Generic RAM: one write port, two read ports, registered read data that
// updates only when read enable is high.
// ----------------------------------------------------------------------------
module bmp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                       rd_data_a,
   output logic [WIDTH-1:0]                       rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/core/bmp_emit.sv =====
// ----------------------------------------------------------------------------
// bmp_emit
// Pixel emitter: holds one decoded data byte and sends its pixels one per
// cycle into the result register while rsp stall does not hold that register.
// ----------------------------------------------------------------------------
module bmp_emit import bmp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  job_type             job_in,
   input  logic [COLOR_W-1:0]  pal_a,
   input  logic [COLOR_W-1:0]  pal_b,
   output logic                job_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PIXEL_W-1:0]  rsp_pixel,
   output logic                rsp_row_end,
   output logic                rsp_last
);

   logic                job_valid_ff;
   mode_type            mode_ff;
   logic [7:0]          bits_ff;
   logic [3:0]          count_ff;
   logic                row_end_ff;
   logic [PIXEL_W-1:0]  px24_ff;
   logic                oob_a_ff;
   logic                oob_b_ff;
   logic                sel_ff;

   logic                rsp_valid_ff;
   logic [PIXEL_W-1:0]  rsp_pixel_ff;
   logic                rsp_row_end_ff;
   logic                rsp_last_ff;

   logic                out_free;
   logic                step;
   logic                final_px;
   logic [PIXEL_W-1:0]  pixel_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = job_valid_ff && out_free;
   assign final_px  = (count_ff == 4'd1);
   assign job_ready = !job_valid_ff || (out_free && final_px);

   always_comb begin
      case (mode_ff)
         MODE_1BPP:  pixel_in = bits_ff[7] ? '1 : '0;
         MODE_4BPP: begin
            if (sel_ff) begin
               pixel_in = oob_b_ff ? '0 : to565(pal_b);
            end else begin
               pixel_in = oob_a_ff ? '0 : to565(pal_a);
            end
         end
         MODE_8BPP:  pixel_in = oob_a_ff ? '0 : to565(pal_a);
         default:    pixel_in = px24_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (job_in.valid) begin
            job_valid_ff <= 1'b1;
         end else if (step && final_px) begin
            job_valid_ff <= 1'b0;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_in.valid) begin
         mode_ff    <= job_in.mode;
         bits_ff    <= job_in.bits;
         count_ff   <= job_in.count;
         row_end_ff <= job_in.row_end;
         px24_ff    <= job_in.px24;
         oob_a_ff   <= job_in.oob_a;
         oob_b_ff   <= job_in.oob_b;
         sel_ff     <= 1'b0;
      end else if (step) begin
         bits_ff  <= {bits_ff[6:0], 1'b0};
         count_ff <= count_ff - 4'd1;
         sel_ff   <= 1'b1;
      end
      if (step) begin
         rsp_pixel_ff   <= pixel_in;
         rsp_last_ff    <= final_px;
         rsp_row_end_ff <= final_px && row_end_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel   = rsp_pixel_ff;
   assign rsp_row_end = rsp_row_end_ff;
   assign rsp_last    = rsp_last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      job_in.valid |-> job_ready)
      else $error("new job loaded over a busy one");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> count_ff != 4'd0)
      else $error("held job has no pixels left");

   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_row_end_ff |-> rsp_last_ff)
      else $error("row end on a pixel that is not the last of its byte");

endmodule

// ===== bench/tb_bmp_pixel_to_rgb565.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_pixel_to_rgb565
// Self-checking bench for the bitmap byte to RGB565 converter. A directed table
// walks the modes, the width extremes, padding, restart and the ignored
// command. Random phases follow, under several register settings, with random
// idling on both sides. Every pixel beat is checked against a predictor kept
// in step with every accepted request beat, or against pixels typed into the table.
// ----------------------------------------------------------------------------
module tb_bmp_pixel_to_rgb565;
   import bmp_pkg::*;

   localparam logic [1:0]  CMD_NONE   = 2'd3;      // undefined command, ignored
   localparam logic [15:0] PX_WHITE   = 16'hFFFF;
   localparam logic [15:0] PX_BLACK   = 16'h0000;
   localparam int          WIDTH_CAP  = 4096;
   localparam int          SETTLE     = 20;        // cycles for in-flight bytes
   localparam int          HOLD_LEN   = 80;
   localparam int          N_PHASES   = 9;
   localparam int          PHASE_LEN  = 14;
   localparam int          PAL_PRELOAD = 16;       // entries 4 bpp can reach

   typedef struct packed {
      logic [15:0] pixel;
      logic        row_end;
      logic        last;
   } px_beat_type;

   // One directed beat; when fixed is set, the pixels are typed in here.
   typedef struct packed {
      mode_type    mode;
      int          width;
      logic [1:0]  cmd;
      logic [7:0]  data;
      logic [7:0]  pidx;
      logic [23:0] pcol;
      bit          fixed;
      int          n_px;
      logic [15:0] px;
      bit          row_end;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_cmd;
   logic [7:0]            req_data_byte;
   logic [7:0]            req_palette_index;
   logic [COLOR_W-1:0]    req_palette_color;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIXEL_W-1:0]    rsp_pixel;
   logic                  rsp_row_end;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predictor state
   mode_type    cur_mode;
   logic [12:0] cur_width;
   logic [23:0] palette [256];
   bit          pal_loaded [256];
   int          column;
   int          row_bytes_seen;
   int          color_phase;
   logic [7:0]  held_b;
   logic [7:0]  held_g;

   px_beat_type fresh_pixels[$];
   px_beat_type expected_pixels[$];
   int          fail_count = 0;
   bit          quiet = 1'b0;
   int          hold_asked = 0;
   int          hold_seen = 0;

   dir_row_type dir_rows [25] = '{
      // 24 bpp after reset: white, black, then a mixed pixel
      '{MODE_24BPP, 320, CMD_DATA, 8'hFF, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_24BPP, 320, CMD_DATA, 8'hFF, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_24BPP, 320, CMD_DATA, 8'hFF, 8'h00, 24'h0, 1'b1, 1, PX_WHITE, 1'b0},
      '{MODE_24BPP, 320, CMD_DATA, 8'h00, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_24BPP, 320, CMD_DATA, 8'h00, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_24BPP, 320, CMD_DATA, 8'h00, 8'h00, 24'h0, 1'b1, 1, PX_BLACK, 1'b0},
      '{MODE_24BPP, 320, CMD_DATA, 8'h12, 8'h00, 24'h0, 1'b0, 0, PX_BLACK, 1'b0},
      '{MODE_24BPP, 320, CMD_DATA, 8'h34, 8'h00, 24'h0, 1'b0, 0, PX_BLACK, 1'b0},
      '{MODE_24BPP, 320, CMD_DATA, 8'h56, 8'h00, 24'h0, 1'b0, 0, PX_BLACK, 1'b0},
      // 1 bpp: full byte, padding byte, restart, ignored command
      '{MODE_1BPP,  8, CMD_RESTART, 8'h00, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_1BPP,  8, CMD_DATA,    8'hFF, 8'h00, 24'h0, 1'b1, 8, PX_WHITE, 1'b1},
      '{MODE_1BPP,  8, CMD_DATA,    8'h00, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_1BPP,  8, CMD_RESTART, 8'h00, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_1BPP,  8, CMD_DATA,    8'h00, 8'h00, 24'h0, 1'b1, 8, PX_BLACK, 1'b1},
      '{MODE_1BPP,  8, CMD_NONE,    8'hFF, 8'hFF, 24'hFFFFFF, 1'b1, 0, PX_BLACK, 1'b0},
      // width cut below the current column in mid-row, then 4 bpp and a palette write read at 8 bpp
      '{MODE_1BPP,  3, CMD_DATA,    8'hA5, 8'h00, 24'h0, 1'b0, 0, PX_BLACK, 1'b0},
      '{MODE_4BPP,  3, CMD_RESTART, 8'h00, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_4BPP,  3, CMD_DATA,    8'h1E, 8'h00, 24'h0, 1'b0, 0, PX_BLACK, 1'b0},
      '{MODE_4BPP,  3, CMD_DATA,    8'hF0, 8'h00, 24'h0, 1'b0, 0, PX_BLACK, 1'b0},
      '{MODE_8BPP,  1, CMD_PALETTE, 8'h00, 8'hFF, 24'hFFFFFF, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_8BPP,  1, CMD_RESTART, 8'h00, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_8BPP,  1, CMD_DATA,    8'hFF, 8'h00, 24'h0, 1'b1, 1, PX_WHITE, 1'b1},
      // zero width ends the row on every byte, oversize width is clamped
      '{MODE_8BPP,  0, CMD_DATA,    8'h00, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_8BPP,  8191, CMD_RESTART, 8'h00, 8'h00, 24'h0, 1'b1, 0, PX_BLACK, 1'b0},
      '{MODE_8BPP,  8191, CMD_DATA, 8'h08, 8'h00, 24'h0, 1'b0, 0, PX_BLACK, 1'b0}
   };

   bmp_pixel_to_rgb565 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel         (rsp_pixel),
      .rsp_row_end       (rsp_row_end),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [15:0] pack565(input logic [23:0] c);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = c[23:16];
      g = c[15:8];
      b = c[7:0];
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   function automatic int clamped_width();
      return (int'(cur_width) > WIDTH_CAP) ? WIDTH_CAP : int'(cur_width);
   endfunction

   function automatic int bits_per_pixel();
      case (cur_mode)
         MODE_1BPP: return 1;
         MODE_4BPP: return 4;
         MODE_8BPP: return 8;
         default:   return 24;
      endcase
   endfunction

   task automatic push_pixel(input logic [15:0] px);
      px_beat_type b;
      if (column < clamped_width() && fresh_pixels.size() < 8) begin
         column++;
         b.pixel   = px;
         b.row_end = (column == clamped_width());
         b.last    = 1'b0;
         fresh_pixels.push_back(b);
      end
   endtask

   // Pixels that one accepted request beat gives, left in fresh_pixels.
   task automatic convert_byte(input logic [1:0] cmd, input logic [7:0] data,
                               input logic [7:0] pidx, input logic [23:0] pcol);
      int          k;
      int          row_len;
      px_beat_type tail;
      fresh_pixels.delete();
      if (cmd == CMD_PALETTE) begin
         palette[pidx]    = pcol;
         pal_loaded[pidx] = 1'b1;
         return;
      end
      if (cmd == CMD_RESTART) begin
         column         = 0;
         row_bytes_seen = 0;
         color_phase    = 0;
         return;
      end
      if (cmd != CMD_DATA)
         return;
      case (cur_mode)
         MODE_1BPP: begin
            for (k = 7; k >= 0; k--)
               push_pixel(data[k] ? PX_WHITE : PX_BLACK);
         end
         MODE_4BPP: begin
            push_pixel(pack565(palette[{4'h0, data[7:4]}]));
            push_pixel(pack565(palette[{4'h0, data[3:0]}]));
         end
         MODE_8BPP: begin
            push_pixel(pack565(palette[data]));
         end
         default: begin
            if (column < clamped_width()) begin
               if (color_phase == 0) begin
                  held_b      = data;
                  color_phase = 1;
               end else if (color_phase == 1) begin
                  held_g      = data;
                  color_phase = 2;
               end else begin
                  color_phase = 0;
                  push_pixel(pack565({data, held_g, held_b}));
               end
            end
         end
      endcase
      row_len = ((clamped_width() * bits_per_pixel() + 31) / 32) * 4;
      row_bytes_seen++;
      if (row_bytes_seen >= row_len) begin
         row_bytes_seen = 0;
         column         = 0;
         color_phase    = 0;
      end
      if (fresh_pixels.size() > 0) begin
         tail = fresh_pixels[fresh_pixels.size()-1];
         tail.last = 1'b1;
         fresh_pixels[fresh_pixels.size()-1] = tail;
      end
   endtask

   // ------------------------------------------------------------------ drivers
   // each cycle idles with a 36% chance, none while quiet
   function automatic int idle_gap();
      int gap;
      gap = 0;
      while (!quiet && $urandom_range(99) < 36)
         gap++;
      return gap;
   endfunction

   // Offers one request beat and waits for it to be taken. valid is left high;
   // the next call lowers it only if it idles first.
   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] data,
                            input logic [7:0] pidx, input logic [23:0] pcol,
                            input bit keep_prediction);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_data_byte     <= data;
      req_palette_index <= pidx;
      req_palette_color <= pcol;
      do @(posedge clock); while (req_stall);
      convert_byte(cmd, data, pidx, pcol);
      if (keep_prediction)
         foreach (fresh_pixels[i]) expected_pixels.push_back(fresh_pixels[i]);
   endtask

   task automatic wait_for_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MODE)
         cur_mode = mode_type'(value[1:0]);
      else if (idx == CSR_WIDTH)
         cur_width = 13'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_format(input mode_type mode, input int width);
      wait_for_pixels();
      write_reg(CSR_MODE, int'(mode));
      write_reg(CSR_WIDTH, width);
   endtask

   task automatic send_random_beat();
      int         pick;
      logic [7:0] data;
      pick = $urandom_range(99);
      data = 8'($urandom);
      // 8 bpp lookups stay on loaded palette entries
      if (cur_mode == MODE_8BPP && !pal_loaded[data])
         data = {4'h0, data[3:0]};
      if (pick < 82)
         send_beat(CMD_DATA, data, 8'($urandom), 24'($urandom), 1'b1);
      else if (pick < 90)
         send_beat(CMD_PALETTE, data, 8'($urandom), 24'($urandom), 1'b1);
      else if (pick < 96)
         send_beat(CMD_RESTART, data, 8'($urandom), 24'($urandom), 1'b1);
      else
         send_beat(CMD_NONE, data, 8'($urandom), 24'($urandom), 1'b1);
   endtask

   // ------------------------------------------------------------ result side
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_seen) begin
            // long hold-off so the converter backs up into req
            hold_seen = hold_asked;
            rsp_stall <= 1'b1;
            repeat (HOLD_LEN - 1) @(negedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 36);
         end
      end
   end

   always @(posedge clock) begin
      px_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("rsp beat with nothing expected: pixel %h", rsp_pixel);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel !== want.pixel) begin
               $error("pixel: expected %h, got %h", want.pixel, rsp_pixel);
               fail_count++;
            end
            if (rsp_row_end !== want.row_end) begin
               $error("row_end: expected %b, got %b", want.row_end, rsp_row_end);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------- main flow
   initial begin
      mode_type    phase_mode  [N_PHASES];
      int          phase_width [N_PHASES];
      px_beat_type b;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_cmd           = CMD_DATA;
      req_data_byte     = 8'h00;
      req_palette_index = 8'h00;
      req_palette_color = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_MODE;
      csr_data          = '0;

      cur_mode       = MODE_24BPP;
      cur_width      = 13'd320;
      column         = 0;
      row_bytes_seen = 0;
      color_phase    = 0;
      held_b         = 8'h00;
      held_g         = 8'h00;

      phase_mode  = '{MODE_1BPP, MODE_4BPP, MODE_8BPP, MODE_24BPP, MODE_1BPP,
                      MODE_24BPP, MODE_4BPP, MODE_1BPP, MODE_1BPP};
      phase_width = '{1, 4096, 7, 5, 13, 0, 8191, 1, 1};
      for (int p = 7; p < N_PHASES; p++) begin
         phase_mode[p]  = mode_type'($urandom_range(3));
         phase_width[p] = $urandom_range(1, 24);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // palette is undefined after reset: load the low entries before any lookup
      for (int i = 0; i < PAL_PRELOAD; i++)
         send_beat(CMD_PALETTE, 8'($urandom), 8'(i), 24'($urandom), 1'b1);

      foreach (dir_rows[r]) begin
         if (dir_rows[r].mode != cur_mode || dir_rows[r].width != int'(cur_width))
            set_format(dir_rows[r].mode, dir_rows[r].width);
         send_beat(dir_rows[r].cmd, dir_rows[r].data, dir_rows[r].pidx,
                   dir_rows[r].pcol, !dir_rows[r].fixed);
         if (dir_rows[r].fixed)
            for (int i = 0; i < dir_rows[r].n_px; i++) begin
               b.pixel   = dir_rows[r].px;
               b.last    = (i == dir_rows[r].n_px - 1);
               b.row_end = dir_rows[r].row_end && b.last;
               expected_pixels.push_back(b);
            end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         set_format(phase_mode[p], phase_width[p]);
         quiet = (p == 1 || p == 2);
         for (int i = 0; i < PHASE_LEN; i++) begin
            if (p == 4 && i == 3)
               hold_asked++;
            if (p == 3 && i == 10)
               wait_for_pixels();
            send_random_beat();
         end
      end
      quiet = 1'b0;

      wait_for_pixels();
      if (fail_count == 0)
         $display("bmp_pixel_to_rgb565: match");
      else
         $display("bmp_pixel_to_rgb565: mismatch");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("bmp_pixel_to_rgb565: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/bmp_pkg.sv
rtl/core/bmp_ram.sv
rtl/core/bmp_emit.sv
rtl/core/bmp_pixel_to_rgb565.sv
bench/tb_bmp_pixel_to_rgb565.sv
